### src/ele_pkg.sv
// Shared types and constants for the echoing line editor.
`timescale 1ns / 1ps
`default_nettype none

package ele_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_READ,
    ST_CHAR,
    ST_END
  } ele_state_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } ele_kind_e;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT  = 2'd1;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RESET    = 6'd32;

  // Result fields
  localparam int unsigned LEN_W = 5;

  typedef struct packed {
    ele_kind_e        kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;
  } ele_res_t;

endpackage

`default_nettype wire

### src/ele_if.sv
// Stream interfaces for received bytes and for result items.
`timescale 1ns / 1ps
`default_nettype none

interface ele_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ele_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [4:0] line_length;
  logic       last;

  modport source (output valid, output kind, output out_byte, output line_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input line_length,
                  input last, output ready);
endinterface

`default_nettype wire

### src/ele_store.sv
// Line store: single write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ele_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/ele_outreg.sv
// Output register between the sequencer and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module ele_outreg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire ele_pkg::ele_res_t in_res_i,
  output logic                   in_ready_o,
  ele_res_if.source              res_o
);

  logic              valid_q, valid_d;
  ele_pkg::ele_res_t res_q;

  // Slot is free when empty or being drained this cycle
  assign in_ready_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= in_res_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.kind        = res_q.kind;
  assign res_o.out_byte    = res_q.out_byte;
  assign res_o.line_length = res_q.line_length;
  assign res_o.last        = res_q.last;

endmodule

`default_nettype wire

### src/ele_ctrl.sv
// Byte decoder and sequencer: echoes, line store updates and line replay.
`timescale 1ns / 1ps
`default_nettype none

module ele_ctrl #(
  parameter int unsigned MAX_LINE = 32,
  parameter int unsigned AW       = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [ele_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ele_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // received bytes
  input  wire logic                           rx_valid_i,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                rx_ready_o,
  // results
  output logic                                res_valid_o,
  output ele_pkg::ele_res_t                   res_o,
  input  wire logic                           res_ready_i,
  // line store
  output logic                                we_o,
  output logic [AW-1:0]                       waddr_o,
  output logic [7:0]                          wdata_o,
  output logic                                re_o,
  output logic [AW-1:0]                       raddr_o,
  input  wire logic [7:0]                     rdata_i
);

  localparam int unsigned LW = (AW + 1 > ele_pkg::CFG_DATA_W) ? AW + 1
                                                              : ele_pkg::CFG_DATA_W;

  ele_pkg::ele_state_e state_q, state_d;

  logic                          echo_en_q;
  logic [ele_pkg::CFG_DATA_W-1:0] limit_q;
  logic [AW-1:0]                 fill_q, fill_d;
  logic                          cr_q, cr_d;
  logic [AW-1:0]                 len_q, len_d;
  logic [AW-1:0]                 idx_q, idx_d;
  logic                          fin_q, fin_d;
  logic [23:0]                   echo_q, echo_d;
  logic [1:0]                    ecnt_q, ecnt_d;

  logic          accept;
  logic [LW-1:0] limit_ext, lim, lim_m1;
  logic [AW-1:0] fill_inc, idx_inc;
  logic          full, full_after, printable, more;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q <= 1'b1;
      limit_q   <= ele_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ele_pkg::CFG_ECHO_ENABLE: echo_en_q <= cfg_data_i[0];
        ele_pkg::CFG_LINE_LIMIT:  limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective limit, clamped to 2..MAX_LINE
  always_comb begin
    limit_ext = LW'(limit_q);
    if (limit_ext < LW'(2)) begin
      lim = LW'(2);
    end else if (limit_ext > LW'(MAX_LINE)) begin
      lim = LW'(MAX_LINE);
    end else begin
      lim = limit_ext;
    end
    lim_m1 = lim - LW'(1);
  end

  assign fill_inc   = fill_q + AW'(1);
  assign full       = LW'(fill_q) >= lim_m1;
  assign full_after = LW'(fill_inc) >= lim_m1;
  assign printable  = (rx_byte_i >= ele_pkg::CH_SPACE) && (rx_byte_i <= ele_pkg::CH_TILDE);
  assign idx_inc    = idx_q + AW'(1);
  assign more       = ((AW + 1)'(idx_q) + (AW + 1)'(1)) < (AW + 1)'(len_q);
  assign accept     = rx_valid_i && rx_ready_o;

  // Datapath updates: byte decode on accept, echo shift, replay index.
  // A stored byte is written at the accept edge, so the replay read that
  // follows always sees it.
  always_comb begin
    fill_d  = fill_q;
    cr_d    = cr_q;
    len_d   = len_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    echo_d  = echo_q;
    ecnt_d  = ecnt_q;
    we_o    = 1'b0;
    waddr_o = fill_q;
    wdata_o = rx_byte_i;

    case (state_q)
      ele_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d  = '0;
          echo_d = '0;
          ecnt_d = 2'd0;
          fin_d  = 1'b0;
          len_d  = fill_q;
          if (full) begin
            // pending line closes, byte discarded
            fin_d  = 1'b1;
            fill_d = '0;
            cr_d   = 1'b0;
          end else if (printable) begin
            cr_d   = 1'b0;
            we_o   = 1'b1;
            fill_d = fill_inc;
            if (echo_en_q) begin
              echo_d = {16'd0, rx_byte_i};
              ecnt_d = 2'd1;
            end
            if (full_after) begin
              fin_d  = 1'b1;
              len_d  = fill_inc;
              fill_d = '0;
            end
          end else if (rx_byte_i == ele_pkg::CH_LF) begin
            if (echo_en_q && cr_q) begin
              echo_d = {8'd0, ele_pkg::CH_LF, ele_pkg::CH_CR};
              ecnt_d = 2'd2;
            end else begin
              echo_d = {16'd0, ele_pkg::CH_LF};
              ecnt_d = 2'd1;
            end
            fin_d  = 1'b1;
            fill_d = '0;
            cr_d   = 1'b0;
          end else if (rx_byte_i == ele_pkg::CH_CR) begin
            if (cr_q) begin
              fin_d  = 1'b1;
              fill_d = '0;
              cr_d   = 1'b0;
            end else begin
              cr_d = 1'b1;
            end
          end else begin
            cr_d = 1'b0;
            if ((rx_byte_i == ele_pkg::CH_BS || rx_byte_i == ele_pkg::CH_DEL) &&
                fill_q != '0) begin
              fill_d = fill_q - AW'(1);
              if (echo_en_q) begin
                echo_d = {ele_pkg::CH_BS, ele_pkg::CH_SPACE, ele_pkg::CH_BS};
                ecnt_d = 2'd3;
              end
            end
          end
        end
      end
      ele_pkg::ST_ECHO: begin
        if (res_ready_i) begin
          echo_d = echo_q >> 8;
          ecnt_d = ecnt_q - 2'd1;
        end
      end
      ele_pkg::ST_CHAR: begin
        if (res_ready_i && more) begin
          idx_d = idx_inc;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ele_pkg::ST_IDLE: begin
        if (accept) begin
          if (ecnt_d != 2'd0) begin
            state_d = ele_pkg::ST_ECHO;
          end else if (fin_d) begin
            state_d = (len_d != '0) ? ele_pkg::ST_READ : ele_pkg::ST_END;
          end
        end
      end
      ele_pkg::ST_ECHO: begin
        if (res_ready_i && ecnt_q == 2'd1) begin
          if (fin_q) begin
            state_d = (len_q != '0) ? ele_pkg::ST_READ : ele_pkg::ST_END;
          end else begin
            state_d = ele_pkg::ST_IDLE;
          end
        end
      end
      ele_pkg::ST_READ: state_d = ele_pkg::ST_CHAR;
      ele_pkg::ST_CHAR: begin
        if (res_ready_i && !more) begin
          state_d = ele_pkg::ST_END;
        end
      end
      ele_pkg::ST_END: begin
        if (res_ready_i) begin
          state_d = ele_pkg::ST_IDLE;
        end
      end
      default: state_d = ele_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rx_ready_o        = 1'b0;
    res_valid_o       = 1'b0;
    res_o.kind        = ele_pkg::KIND_ECHO;
    res_o.out_byte    = echo_q[7:0];
    res_o.line_length = '0;
    res_o.last        = 1'b0;
    re_o              = 1'b0;
    raddr_o           = idx_q;
    unique case (state_q)
      ele_pkg::ST_IDLE: rx_ready_o = 1'b1;
      ele_pkg::ST_ECHO: begin
        res_valid_o = 1'b1;
        res_o.last  = (ecnt_q == 2'd1) && !fin_q;
      end
      ele_pkg::ST_READ: re_o = 1'b1;
      ele_pkg::ST_CHAR: begin
        res_valid_o    = 1'b1;
        res_o.kind     = ele_pkg::KIND_CHAR;
        res_o.out_byte = rdata_i;
        // fetch the next character as this one leaves
        if (res_ready_i && more) begin
          re_o    = 1'b1;
          raddr_o = idx_inc;
        end
      end
      ele_pkg::ST_END: begin
        res_valid_o       = 1'b1;
        res_o.kind        = ele_pkg::KIND_END;
        res_o.out_byte    = 8'd0;
        res_o.line_length = ele_pkg::LEN_W'(len_q);
        res_o.last        = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ele_pkg::ST_IDLE;
      fill_q  <= '0;
      cr_q    <= 1'b0;
      fin_q   <= 1'b0;
      ecnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cr_q    <= cr_d;
      fin_q   <= fin_d;
      ecnt_q  <= ecnt_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    idx_q  <= idx_d;
    echo_q <= echo_d;
  end

endmodule

`default_nettype wire

### src/echoing_line_editor_top.sv
// Top level of the echoing line editor.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------
//  rx_i    | in  | valid/ready   | rx_byte[7:0]
//  res_o   | out | valid/ready   | kind[1:0] out_byte[7:0] line_length[4:0] last
//  cfg     | in  | cfg_we_i      | cfg_idx_i[1:0] cfg_data_i[5:0]
//
// A byte is taken when idle; each of its echoes then leaves as its own result.
// A completed line passes a store read state, then one result per stored
// character and one for the end marker; the store's registered read port
// is why the read state comes first, and it is skipped for an empty line.
// Reset clears control state only; store contents stay undefined until written.
// Output stalls hold the sequencer; no new byte is taken until its results are queued.
`timescale 1ns / 1ps
`default_nettype none

module echoing_line_editor_top #(
  parameter int unsigned MAX_LINE = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ele_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ele_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ele_rx_if.sink                              rx_i,
  ele_res_if.source                           res_o
);

  localparam int unsigned AW = $clog2(MAX_LINE);

  logic              res_valid, res_ready;
  ele_pkg::ele_res_t res;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [7:0]        wdata, rdata;
  logic              rx_ready;

  assign rx_i.ready = rx_ready;

  ele_ctrl #(
    .MAX_LINE (MAX_LINE),
    .AW       (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_valid_i  (rx_i.valid),
    .rx_byte_i   (rx_i.rx_byte),
    .rx_ready_o  (rx_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  ele_store #(
    .DEPTH (MAX_LINE),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ele_outreg u_outreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_res_i   (res),
    .in_ready_o (res_ready),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

### tb/echoing_line_editor_top_tb.sv
// Self-checking testbench for the echoing line editor: directed and random byte streams.
`timescale 1ns / 1ps

module echoing_line_editor_top_tb;
  import ele_pkg::*;

  localparam int unsigned STORE_DEPTH    = 32;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 45;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_TX,
    IDLE_RX,
    IDLE_BOTH
  } idle_mode_e;

  // Line editor predictor and queue of expected results
  class line_echo_scoreboard;
    logic [7:0]           line_chars [STORE_DEPTH];
    int unsigned          fill = 0;
    bit                   cr_seen = 1'b0;
    bit                   echo_on = 1'b1;
    logic [CFG_DATA_W-1:0] limit_reg = LIMIT_RESET;
    ele_res_t             expected_q [$];
    ele_res_t             step_q [$];
    int unsigned          errors = 0;

    function int unsigned line_cap();
      int unsigned cap;
      cap = limit_reg;
      if (cap < 2) cap = 2;
      if (cap > STORE_DEPTH) cap = STORE_DEPTH;
      return cap;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ECHO_ENABLE) echo_on = data[0];
      else if (idx == CFG_LINE_LIMIT) limit_reg = data;
    endfunction

    function void add_result(ele_kind_e kind, logic [7:0] ch, logic [LEN_W-1:0] len);
      ele_res_t r;
      r.kind        = kind;
      r.out_byte    = ch;
      r.line_length = len;
      r.last        = 1'b0;
      step_q.push_back(r);
    endfunction

    // Replay the stored line, then the end marker
    function void close_line();
      for (int unsigned i = 0; i < fill; i++) add_result(KIND_CHAR, line_chars[i], '0);
      add_result(KIND_END, '0, LEN_W'(fill));
      fill    = 0;
      cr_seen = 1'b0;
    endfunction

    function void note_rx_byte(logic [7:0] ch);
      int unsigned cap;
      cap = line_cap();
      step_q.delete();
      if (fill >= cap - 1) begin
        // limit dropped under the fill: byte is dropped, line flushed
        close_line();
      end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
        cr_seen = 1'b0;
        line_chars[fill] = ch;
        fill++;
        if (echo_on) add_result(KIND_ECHO, ch, '0);
        if (fill >= cap - 1) close_line();
      end else if (ch == CH_LF) begin
        if (echo_on && cr_seen) add_result(KIND_ECHO, CH_CR, '0);
        add_result(KIND_ECHO, CH_LF, '0);
        close_line();
      end else if (ch == CH_CR) begin
        if (cr_seen) close_line();
        else cr_seen = 1'b1;
      end else begin
        cr_seen = 1'b0;
        if ((ch == CH_BS || ch == CH_DEL) && fill > 0) begin
          fill--;
          if (echo_on) begin
            add_result(KIND_ECHO, CH_BS, '0);
            add_result(KIND_ECHO, CH_SPACE, '0);
            add_result(KIND_ECHO, CH_BS, '0);
          end
        end
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] ch, logic [LEN_W-1:0] len,
                               logic last);
      ele_res_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d, out_byte %0d, line_length %0d, last %0d",
               kind, ch, len, last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (kind !== exp_r.kind) begin
        $error("kind: expected %0d, actual %0d", exp_r.kind, kind);
        errors++;
      end
      if (ch !== exp_r.out_byte) begin
        $error("out_byte: expected %0d, actual %0d", exp_r.out_byte, ch);
        errors++;
      end
      if (len !== exp_r.line_length) begin
        $error("line_length: expected %0d, actual %0d", exp_r.line_length, len);
        errors++;
      end
      if (last !== exp_r.last) begin
        $error("last: expected %0d, actual %0d", exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  idle_mode_e            idle_mode = IDLE_NONE;
  bit                    long_hold_req = 1'b0;
  line_echo_scoreboard   sb;

  // Opening bytes: erasure on an empty line, extremes, CR/LF forms, controls
  logic [7:0] directed_seq [25] = '{
    CH_BS, CH_DEL, CH_SPACE, CH_TILDE, CH_BS, CH_DEL, 8'h48, 8'h69, CH_CR, CH_LF,
    CH_CR, CH_CR, 8'h61, CH_CR, CH_CR, CH_LF, 8'h00, 8'hFF, 8'h80, 8'h09,
    8'h62, CH_CR, 8'h00, CH_CR, CH_LF
  };

  ele_rx_if  rx_if ();
  ele_res_if res_if ();

  echoing_line_editor_top #(
    .MAX_LINE(STORE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always #10 clk_i = ~clk_i;

  // Offer one byte, with a random gap first, and wait for its transfer
  task automatic send_byte(input logic [7:0] ch);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_TX) ? 47 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    while ($urandom_range(99) < gap_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= ch;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.note_rx_byte(ch);
  endtask

  // Wait for all expected results, then let any silent byte finish
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input bit echo, input logic [CFG_DATA_W-1:0] limit);
    logic [CFG_DATA_W-1:0] echo_word;
    wait_idle();
    echo_word  = {5'($urandom), echo};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ECHO_ENABLE;
    cfg_data_i <= echo_word;
    @(posedge clk_i);
    sb.write_reg(CFG_ECHO_ENABLE, echo_word);
    cfg_idx_i  <= CFG_LINE_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    sb.write_reg(CFG_LINE_LIMIT, limit);
    cfg_we_i   <= 1'b0;
  endtask

  // One typed line: printable text with some erasure and noise, then LF, CR LF, CR CR or no terminator
  task automatic send_random_line(inout int unsigned sent);
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(sb.line_cap());
    for (int unsigned k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_byte($urandom_range(1) ? CH_BS : CH_DEL);
        sent++;
      end else if (pick < 12) begin
        send_byte($urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255, 128)));
        sent++;
      end else begin
        send_byte(8'($urandom_range(CH_TILDE, CH_SPACE)));
        sent++;
      end
    end
    case ($urandom_range(3))
      0: begin
        send_byte(CH_LF);
        sent++;
      end
      1: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
        sent += 2;
      end
      2: begin
        send_byte(CH_CR);
        send_byte(CH_CR);
        sent += 2;
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(input bit echo, input logic [CFG_DATA_W-1:0] limit,
                           input idle_mode_e mode, input bit hold);
    int unsigned sent;
    set_config(echo, limit);
    idle_mode     <= mode;
    long_hold_req <= hold;
    sent = 0;
    while (sent < PHASE_ITEMS) send_random_line(sent);
    long_hold_req <= 1'b0;
  endtask

  // Receiver: checks each result transfer and drives ready
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    int unsigned stall_pct;
    hold_left  = 0;
    hold_taken = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready)
        sb.check_result(res_if.kind, res_if.out_byte, res_if.line_length, res_if.last);
      if (long_hold_req && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end else if (!long_hold_req) begin
        hold_taken = 1'b0;
      end
      stall_pct = (idle_mode == IDLE_RX) ? 47 : (idle_mode == IDLE_BOTH) ? 26 : 0;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: too long without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("echoing_line_editor_top_tb: done, errors");
    $finish;
  end

  // Main sequence
  initial begin
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_ECHO_ENABLE;
    cfg_data_i    <= '0;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: echo on, full-size line
    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    // limit lowered below a partial line: next byte flushes it
    send_byte(8'h70);
    send_byte(8'h71);
    send_byte(8'h72);
    set_config(1'b1, 6'd2);
    send_byte(8'h7A);
    send_byte(8'h41);

    // random phases across settings and idling patterns
    run_phase(1'b1, 6'd32, IDLE_NONE, 1'b0);
    run_phase(1'b1, 6'd32, IDLE_TX,   1'b0);
    run_phase(1'b0, 6'd8,  IDLE_RX,   1'b0);
    run_phase(1'b1, 6'd0,  IDLE_BOTH, 1'b0);
    run_phase(1'b1, 6'd63, IDLE_NONE, 1'b1);
    run_phase(1'b0, 6'd1,  IDLE_TX,   1'b0);
    run_phase(1'b1, 6'($urandom_range(32, 2)), IDLE_RX, 1'b0);
    run_phase(1'b1, 6'd3,  IDLE_BOTH, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("echoing_line_editor_top_tb: done, clean");
    else
      $display("echoing_line_editor_top_tb: done, errors");
    $finish;
  end

endmodule

### files.f
src/ele_pkg.sv
src/ele_if.sv
src/ele_store.sv
src/ele_outreg.sv
src/ele_ctrl.sv
src/echoing_line_editor_top.sv
tb/echoing_line_editor_top_tb.sv
